// File: rtl/bcmg_pkg.sv
// ============================================================================
// bcmg_pkg: shared types and constants of the button chord motion gesture block
// Item and result structs, command codes, register indexes and the fixed-point
// sine and cosine constants used by the sector compares.
// ============================================================================
`default_nettype none

package bcmg_pkg;

    localparam int NUM_DIRECTIONS = 8;
    localparam int DIR_W          = 3;
    localparam int BTN_W          = 3;
    localparam int KEY_W          = 16;
    localparam int MOVE_W         = 16;
    localparam int STEP_W         = 12;
    localparam int HOLD_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // Queue depths between the parts of the block.
    localparam int IN_DEPTH   = 4;
    localparam int IN_PTR_W   = $clog2(IN_DEPTH);
    localparam int IN_CNT_W   = $clog2(IN_DEPTH + 1);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    // Register reset values.
    localparam logic              ENABLE_RESET = 1'b1;
    localparam logic [STEP_W-1:0] STEP_RESET   = 12'd100;
    localparam logic [HOLD_W-1:0] HOLD_RESET   = 16'd0;

    // Direction codes, east first and then clockwise.
    localparam logic [DIR_W-1:0] DIR_E = 3'd0;
    localparam logic [DIR_W-1:0] DIR_SE = 3'd1;
    localparam logic [DIR_W-1:0] DIR_S = 3'd2;
    localparam logic [DIR_W-1:0] DIR_SW = 3'd3;
    localparam logic [DIR_W-1:0] DIR_W_ = 3'd4;
    localparam logic [DIR_W-1:0] DIR_N = 3'd6;

    // Q30 sine and cosine of 23 and 68 degrees, with the negated forms.
    localparam logic signed [31:0] Q_C23  = 32'sd988384560;
    localparam logic signed [31:0] Q_S23  = 32'sd419544355;
    localparam logic signed [31:0] Q_C68  = 32'sd402230767;
    localparam logic signed [31:0] Q_S68  = 32'sd995556083;
    localparam logic signed [31:0] Q_NS23 = -32'sd419544355;
    localparam logic signed [31:0] Q_NS68 = -32'sd995556083;

    typedef enum logic [1:0] {
        KIND_MOTION = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_SLOT   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_STEP   = 2'd1,
        CFG_HOLD   = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        OP_MOTION = 4'b0001,
        OP_BUTTON = 4'b0010,
        OP_TICK   = 4'b0100,
        OP_SLOT   = 4'b1000
    } t_op;

    typedef struct packed {
        t_kind                     kind;
        logic [BTN_W-1:0]          button_index;
        logic                      pressed;
        logic signed [MOVE_W-1:0]  move_x;
        logic signed [MOVE_W-1:0]  move_y;
        logic [DIR_W-1:0]          slot_direction;
        logic [KEY_W-1:0]          slot_keycode;
    } t_in_item;

    typedef struct packed {
        logic signed [MOVE_W-1:0]  pass_x;
        logic signed [MOVE_W-1:0]  pass_y;
        logic                      tap_valid;
        logic [KEY_W-1:0]          tap_keycode;
    } t_result;

    typedef struct packed {
        t_op                       op;
        logic [BTN_W-1:0]          button;
        logic                      pressed;
        logic signed [MOVE_W-1:0]  move_x;
        logic signed [MOVE_W-1:0]  move_y;
        logic [DIR_W-1:0]          direction;
        logic [KEY_W-1:0]          keycode;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

endpackage

`default_nettype wire

// File: rtl/button_chord_motion_gesture.sv
// Path: a motion item passes the input queue, issue stage and second and third
// stages into the result queue; other kinds produce no result.
// Throughput: one item per cycle unless a motion item waits for room in the
// result queue, set by the accumulate and distance test in the issue stage.
// Reset: synchronous, active low; clears queues, chord state and slot flags
// at once, and the registers return to enable 1, step 100, hold 0.
// ============================================================================
// button_chord_motion_gesture: pointer motion to key taps while a chord is held
// A front end decodes and queues items, a back end keeps the chord state and
// slot table, and a result queue holds the motion results for the consumer.
// ============================================================================
`default_nettype none

module button_chord_motion_gesture #(
    parameter int NUM_BUTTONS = 5,
    parameter int ACCUM_WIDTH = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire bcmg_pkg::t_in_item               i_item,
    output logic                                  empty,
    input  wire logic                             pop,
    output bcmg_pkg::t_result                     o_result,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [bcmg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bcmg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    bcmg_pkg::t_cmd_head               head;
    logic                              back_pop;
    logic                              res_push;
    bcmg_pkg::t_result                 res_data;
    logic [bcmg_pkg::OUT_CNT_W-1:0]    out_count;

    bcmg_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .i_pop   (back_pop),
        .o_head  (head)
    );

    bcmg_back #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .ACCUM_WIDTH (ACCUM_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_pop       (back_pop),
        .i_out_count (out_count),
        .o_push      (res_push),
        .o_result    (res_data)
    );

    bcmg_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result),
        .o_count (out_count)
    );

endmodule

`default_nettype wire

// File: rtl/bcmg_front.sv
// ============================================================================
// bcmg_front: input side of the gesture block
// Accepts items, decodes them into commands, drops events for buttons that do
// not exist, and holds the commands in a short queue for the back end.
// ============================================================================
`default_nettype none

module bcmg_front #(
    parameter int NUM_BUTTONS = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire bcmg_pkg::t_in_item  i_item,
    input  wire logic                i_pop,
    output bcmg_pkg::t_cmd_head      o_head
);

    bcmg_pkg::t_cmd                      r_mem [bcmg_pkg::IN_DEPTH];
    logic [bcmg_pkg::IN_PTR_W-1:0]       r_wr_ptr;
    logic [bcmg_pkg::IN_PTR_W-1:0]       r_rd_ptr;
    logic [bcmg_pkg::IN_CNT_W-1:0]       r_count;
    logic [bcmg_pkg::IN_CNT_W-1:0]       n_count;

    bcmg_pkg::t_cmd cmd;
    logic           keep;
    logic           btn_ok;
    logic           wr;

    assign btn_ok = (4'(i_item.button_index) < 4'(NUM_BUTTONS));

    always_comb begin
        cmd.button    = i_item.button_index;
        cmd.pressed   = i_item.pressed;
        cmd.move_x    = i_item.move_x;
        cmd.move_y    = i_item.move_y;
        cmd.direction = i_item.slot_direction;
        cmd.keycode   = i_item.slot_keycode;
        cmd.op        = bcmg_pkg::OP_MOTION;
        keep          = 1'b1;
        case (i_item.kind)
            bcmg_pkg::KIND_MOTION: begin
                cmd.op = bcmg_pkg::OP_MOTION;
            end
            bcmg_pkg::KIND_BUTTON: begin
                cmd.op = bcmg_pkg::OP_BUTTON;
                keep   = btn_ok;
            end
            bcmg_pkg::KIND_TICK: begin
                cmd.op = bcmg_pkg::OP_TICK;
            end
            bcmg_pkg::KIND_SLOT: begin
                cmd.op = bcmg_pkg::OP_SLOT;
                keep   = btn_ok;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full = (r_count == bcmg_pkg::IN_CNT_W'(bcmg_pkg::IN_DEPTH));
    // Events for missing buttons are accepted but never queued.
    assign wr     = i_push && !o_full && keep;

    always_comb begin
        n_count = r_count;
        if (wr && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!wr && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// File: rtl/bcmg_out_queue.sv
// ============================================================================
// bcmg_out_queue: result queue of the gesture block
// Holds finished results until the consumer pops them and reports its fill
// level so the back end can reserve room before it issues a motion item.
// ============================================================================
`default_nettype none

module bcmg_out_queue (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire bcmg_pkg::t_result          i_data,
    input  wire logic                       i_pop,
    output logic                            o_empty,
    output bcmg_pkg::t_result               o_data,
    output logic [bcmg_pkg::OUT_CNT_W-1:0]  o_count
);

    bcmg_pkg::t_result                 r_mem [bcmg_pkg::OUT_DEPTH];
    logic [bcmg_pkg::OUT_PTR_W-1:0]    r_wr_ptr;
    logic [bcmg_pkg::OUT_PTR_W-1:0]    r_rd_ptr;
    logic [bcmg_pkg::OUT_CNT_W-1:0]    r_count;
    logic [bcmg_pkg::OUT_CNT_W-1:0]    n_count;
    logic                              rd;

    assign o_empty = (r_count == '0);
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (i_push && !rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// File: rtl/bcmg_back.sv
// ============================================================================
// bcmg_back: execution side of the gesture block
// Updates chord state, accumulates captured motion and decides on firing in
// the issue stage, then bins the sector and reads the slot table in two more
// stages before the result enters the output queue.
// ============================================================================
`default_nettype none

module bcmg_back #(
    parameter int NUM_BUTTONS = 5,
    parameter int ACCUM_WIDTH = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [bcmg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bcmg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire bcmg_pkg::t_cmd_head                 i_head,
    output logic                                     o_pop,
    input  wire logic [bcmg_pkg::OUT_CNT_W-1:0]      i_out_count,
    output logic                                     o_push,
    output bcmg_pkg::t_result                        o_result
);

    localparam int AW      = ACCUM_WIDTH;
    localparam int SLOT_N  = NUM_BUTTONS * bcmg_pkg::NUM_DIRECTIONS;
    localparam int SLOT_AW = $clog2(SLOT_N);
    localparam int SQ_W    = 2 * AW + 1;
    localparam int PW      = AW + 34;
    localparam int ND      = bcmg_pkg::NUM_DIRECTIONS;

    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    // Configuration and chord state.
    logic                          r_enable, n_enable;
    logic [bcmg_pkg::STEP_W-1:0]   r_step, n_step;
    logic [bcmg_pkg::HOLD_W-1:0]   r_hold, n_hold;
    logic [NUM_BUTTONS-1:0]        r_held, n_held;
    logic                          r_act_valid, n_act_valid;
    logic [bcmg_pkg::BTN_W-1:0]    r_act_btn, n_act_btn;
    logic signed [AW-1:0]          r_acc_x, n_acc_x;
    logic signed [AW-1:0]          r_acc_y, n_acc_y;
    logic [bcmg_pkg::HOLD_W-1:0]   r_elapsed, n_elapsed;
    logic [SLOT_N-1:0]             r_slot_nz;
    logic [bcmg_pkg::KEY_W-1:0]    slot_mem [SLOT_N];

    // Second stage: fired vector waiting for sector binning.
    logic                          r_p2_valid;
    logic                          r_p2_fire;
    logic signed [AW-1:0]          r_p2_x;
    logic signed [AW-1:0]          r_p2_y;
    logic [bcmg_pkg::BTN_W-1:0]    r_p2_btn;
    logic signed [bcmg_pkg::MOVE_W-1:0] r_p2_pass_x;
    logic signed [bcmg_pkg::MOVE_W-1:0] r_p2_pass_y;

    // Third stage: slot data read back from the table.
    logic                          r_p3_valid;
    logic                          r_p3_fire;
    logic                          r_p3_odd;
    logic signed [bcmg_pkg::MOVE_W-1:0] r_p3_pass_x;
    logic signed [bcmg_pkg::MOVE_W-1:0] r_p3_pass_y;
    logic [bcmg_pkg::KEY_W-1:0]    r_p3_key_dir;
    logic [bcmg_pkg::KEY_W-1:0]    r_p3_key_card;
    logic                          r_p3_nz_dir;
    logic                          r_p3_nz_card;

    bcmg_pkg::t_cmd                cmd;
    logic                          issue;
    logic                          is_motion;
    logic                          is_slot;
    logic                          credit;
    logic [bcmg_pkg::OUT_CNT_W:0]  pending;
    logic                          capturing;
    logic signed [AW:0]            sum_x, sum_y;
    logic signed [AW-1:0]          sat_x, sat_y;
    logic [AW-1:0]                 abs_x, abs_y;
    logic [2*AW-1:0]               sq_x, sq_y;
    logic [SQ_W-1:0]               dist2;
    logic [2*bcmg_pkg::STEP_W-1:0] step2;
    logic                          fire;
    logic [NUM_BUTTONS-1:0]        btn_bit;
    logic [NUM_BUTTONS-1:0]        held_evt;
    logic                          new_valid;
    logic [bcmg_pkg::BTN_W-1:0]    new_btn;
    logic                          act_changed;
    logic [SLOT_AW-1:0]            addr_wr;

    assign cmd       = i_head.cmd;
    assign is_motion = (cmd.op == bcmg_pkg::OP_MOTION);
    assign is_slot   = (cmd.op == bcmg_pkg::OP_SLOT);

    // A motion item issues only when the output queue has room for it and
    // for every motion item still in the later stages.
    assign pending = (bcmg_pkg::OUT_CNT_W+1)'(i_out_count)
                   + (bcmg_pkg::OUT_CNT_W+1)'(r_p2_valid)
                   + (bcmg_pkg::OUT_CNT_W+1)'(r_p3_valid);
    assign credit  = pending < (bcmg_pkg::OUT_CNT_W+1)'(bcmg_pkg::OUT_DEPTH);
    assign issue   = i_head.valid && (!is_motion || credit);
    assign o_pop   = issue;

    assign capturing = r_enable && r_act_valid && (r_elapsed >= r_hold);

    // Saturating accumulate and the distance test.
    assign sum_x = (AW+1)'(r_acc_x) + (AW+1)'(cmd.move_x);
    assign sum_y = (AW+1)'(r_acc_y) + (AW+1)'(cmd.move_y);
    assign sat_x = (sum_x[AW] != sum_x[AW-1]) ? (sum_x[AW] ? ACC_MIN : ACC_MAX)
                                              : sum_x[AW-1:0];
    assign sat_y = (sum_y[AW] != sum_y[AW-1]) ? (sum_y[AW] ? ACC_MIN : ACC_MAX)
                                              : sum_y[AW-1:0];
    assign abs_x = sat_x[AW-1] ? AW'(-sat_x) : AW'(sat_x);
    assign abs_y = sat_y[AW-1] ? AW'(-sat_y) : AW'(sat_y);
    assign sq_x  = abs_x * abs_x;
    assign sq_y  = abs_y * abs_y;
    assign dist2 = SQ_W'(sq_x) + SQ_W'(sq_y);
    assign step2 = r_step * r_step;
    assign fire  = capturing && (dist2 >= SQ_W'(step2));

    // New active button: the lowest held button that owns a nonzero slot.
    assign btn_bit  = NUM_BUTTONS'(1) << cmd.button;
    assign held_evt = cmd.pressed ? (r_held | btn_bit) : (r_held & ~btn_bit);

    always_comb begin
        new_valid = 1'b0;
        new_btn   = '0;
        for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
            if (held_evt[b] && (|r_slot_nz[b*ND +: ND])) begin
                new_valid = 1'b1;
                new_btn   = bcmg_pkg::BTN_W'(b);
            end
        end
    end

    assign act_changed = (new_valid != r_act_valid) || (new_valid && (new_btn != r_act_btn));

    always_comb begin
        n_enable    = r_enable;
        n_step      = r_step;
        n_hold      = r_hold;
        n_held      = r_held;
        n_act_valid = r_act_valid;
        n_act_btn   = r_act_btn;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_elapsed   = r_elapsed;
        if (issue) begin
            case (cmd.op)
                bcmg_pkg::OP_MOTION: begin
                    if (capturing) begin
                        n_acc_x = fire ? '0 : sat_x;
                        n_acc_y = fire ? '0 : sat_y;
                    end
                end
                bcmg_pkg::OP_BUTTON: begin
                    n_held      = held_evt;
                    n_act_valid = new_valid;
                    n_act_btn   = new_btn;
                    if (act_changed) begin
                        n_acc_x   = '0;
                        n_acc_y   = '0;
                        n_elapsed = '0;
                    end
                end
                bcmg_pkg::OP_TICK: begin
                    if (r_elapsed != '1) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bcmg_pkg::CFG_ENABLE: begin
                    n_enable = i_cfg_wdata[0];
                    if (!i_cfg_wdata[0]) begin
                        n_act_valid = 1'b0;
                        n_act_btn   = '0;
                        n_acc_x     = '0;
                        n_acc_y     = '0;
                    end
                end
                bcmg_pkg::CFG_STEP: begin
                    n_step = i_cfg_wdata[bcmg_pkg::STEP_W-1:0];
                end
                bcmg_pkg::CFG_HOLD: begin
                    n_hold = i_cfg_wdata[bcmg_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign addr_wr = SLOT_AW'({cmd.button, cmd.direction});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= bcmg_pkg::ENABLE_RESET;
            r_step      <= bcmg_pkg::STEP_RESET;
            r_hold      <= bcmg_pkg::HOLD_RESET;
            r_held      <= '0;
            r_act_valid <= 1'b0;
            r_act_btn   <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_elapsed   <= '0;
            r_slot_nz   <= '0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
        end else begin
            r_enable    <= n_enable;
            r_step      <= n_step;
            r_hold      <= n_hold;
            r_held      <= n_held;
            r_act_valid <= n_act_valid;
            r_act_btn   <= n_act_btn;
            r_acc_x     <= n_acc_x;
            r_acc_y     <= n_acc_y;
            r_elapsed   <= n_elapsed;
            r_p2_valid  <= issue && is_motion;
            r_p3_valid  <= r_p2_valid;
            // The nonzero flags double as valid bits for the slot memory.
            if (issue && is_slot) begin
                r_slot_nz[addr_wr] <= (cmd.keycode != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_fire   <= fire;
        r_p2_x      <= sat_x;
        r_p2_y      <= sat_y;
        r_p2_btn    <= r_act_btn;
        r_p2_pass_x <= capturing ? '0 : cmd.move_x;
        r_p2_pass_y <= capturing ? '0 : cmd.move_y;
    end

    // Sector binning by cross-product compares against the sector edges.
    logic [AW-1:0]            ay2, ax2;
    logic signed [PW-1:0]     ay_w, x_w;
    logic signed [PW-1:0]     e23, e68, e113, e158;
    logic [bcmg_pkg::DIR_W-1:0] half_sect;
    logic [bcmg_pkg::DIR_W-1:0] sect;
    logic [bcmg_pkg::DIR_W-1:0] card;
    logic [SLOT_AW-1:0]       addr_dir, addr_card;

    assign ay2  = r_p2_y[AW-1] ? AW'(-r_p2_y) : AW'(r_p2_y);
    assign ax2  = r_p2_x[AW-1] ? AW'(-r_p2_x) : AW'(r_p2_x);
    assign ay_w = PW'($signed({1'b0, ay2}));
    assign x_w  = PW'(r_p2_x);
    assign e23  = ay_w * PW'(bcmg_pkg::Q_C23)  - x_w * PW'(bcmg_pkg::Q_S23);
    assign e68  = ay_w * PW'(bcmg_pkg::Q_C68)  - x_w * PW'(bcmg_pkg::Q_S68);
    assign e113 = ay_w * PW'(bcmg_pkg::Q_NS23) - x_w * PW'(bcmg_pkg::Q_C23);
    assign e158 = ay_w * PW'(bcmg_pkg::Q_NS68) - x_w * PW'(bcmg_pkg::Q_C68);

    always_comb begin
        if (e23[PW-1]) begin
            half_sect = bcmg_pkg::DIR_E;
        end else if (e68[PW-1]) begin
            half_sect = bcmg_pkg::DIR_SE;
        end else if (e113[PW-1]) begin
            half_sect = bcmg_pkg::DIR_S;
        end else if (e158[PW-1]) begin
            half_sect = bcmg_pkg::DIR_SW;
        end else begin
            half_sect = bcmg_pkg::DIR_W_;
        end
        // The north half mirrors the south half; a zero vector counts as east.
        if ((r_p2_x == '0) && (r_p2_y == '0)) begin
            sect = bcmg_pkg::DIR_E;
        end else if (r_p2_y[AW-1]) begin
            sect = 3'd0 - half_sect;
        end else begin
            sect = half_sect;
        end
        if (ax2 >= ay2) begin
            card = r_p2_x[AW-1] ? bcmg_pkg::DIR_W_ : bcmg_pkg::DIR_E;
        end else begin
            card = r_p2_y[AW-1] ? bcmg_pkg::DIR_N : bcmg_pkg::DIR_S;
        end
    end

    assign addr_dir  = SLOT_AW'({r_p2_btn, sect});
    assign addr_card = SLOT_AW'({r_p2_btn, card});

    always_ff @(posedge i_clk) begin
        if (issue && is_slot) begin
            slot_mem[addr_wr] <= cmd.keycode;
        end
        r_p3_key_dir  <= slot_mem[addr_dir];
        r_p3_key_card <= slot_mem[addr_card];
    end

    always_ff @(posedge i_clk) begin
        r_p3_nz_dir  <= r_slot_nz[addr_dir];
        r_p3_nz_card <= r_slot_nz[addr_card];
        r_p3_fire    <= r_p2_fire;
        r_p3_odd     <= sect[0];
        r_p3_pass_x  <= r_p2_pass_x;
        r_p3_pass_y  <= r_p2_pass_y;
    end

    // An empty diagonal falls back to the dominant-axis cardinal.
    logic [bcmg_pkg::KEY_W-1:0] key_dir, key_card, key;

    assign key_dir  = r_p3_nz_dir  ? r_p3_key_dir  : '0;
    assign key_card = r_p3_nz_card ? r_p3_key_card : '0;

    always_comb begin
        if (!r_p3_fire) begin
            key = '0;
        end else if ((key_dir == '0) && r_p3_odd) begin
            key = key_card;
        end else begin
            key = key_dir;
        end
    end

    assign o_push               = r_p3_valid;
    assign o_result.pass_x      = r_p3_pass_x;
    assign o_result.pass_y      = r_p3_pass_y;
    assign o_result.tap_valid   = (key != '0);
    assign o_result.tap_keycode = key;

endmodule

`default_nettype wire

// File: rtl/bcmg_checker.sv
// ============================================================================
// bcmg_checker: port-level checks of the gesture block
// Watches the result side and reset behavior and is bound to the top level.
// ============================================================================
`default_nettype none

module bcmg_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire bcmg_pkg::t_result  o_result
);

    // Reset leaves the result queue empty and the input queue not full.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A result without a tap carries a zero keycode.
    a_no_tap_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.tap_valid) |-> (o_result.tap_keycode == '0))
        else $error("keycode set without a tap");

    // Taps only come from captured motion, which passes no motion on.
    a_tap_no_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.tap_valid) |-> ((o_result.pass_x == '0) && (o_result.pass_y == '0)))
        else $error("tap with motion passed on");

    // A waiting result stays put until it is popped.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed without a pop");

endmodule

bind button_chord_motion_gesture bcmg_checker u_bcmg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

`default_nettype wire
